// ----- rtl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Table geometry, operation and status codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int DEPTH       = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int AW          = $clog2(DEPTH);
  localparam int CW          = AW + 1;

  localparam logic [2:0] OP_INSERT   = 3'd0;
  localparam logic [2:0] OP_FIND     = 3'd1;
  localparam logic [2:0] OP_FIND_ALL = 3'd2;
  localparam logic [2:0] OP_DEL_ONE  = 3'd3;
  localparam logic [2:0] OP_DEL_ALL  = 3'd4;
  localparam logic [2:0] OP_READ_AT  = 3'd5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    DC_NOP, DC_LOAD, DC_RD_MID, DC_SRCH, DC_RD_IDX, DC_SET_RUN, DC_RD_DN,
    DC_STEP_DN, DC_RD_UP, DC_STEP_UP, DC_SET_AT, DC_INS_INIT, DC_RD_PTR,
    DC_MOV_UP, DC_INS_WR, DC_RM_INIT, DC_MOV_DN, DC_RM_DONE, DC_PTR_RB, DC_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    EM_MISS, EM_INS, EM_SAVED, EM_RDAT, EM_RANGE
  } emit_t;

  typedef struct packed {
    dp_op_t  op;
    emit_t   sel;
    status_t st;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       lo_le_hi;
    logic       eq;
    logic       hit;
    logic       rb_gt0;
    logic       up_ok;
    logic       ptr_ge_rb;
    logic       ptr_lt_cnt;
    logic       idx_ok;
    logic       full;
    logic       fa_last;
    logic       out_busy;
  } dp_stat_t;

endpackage

// ----- rtl/skt_if.sv -----
// ----------------------------------------------------------------------------
// skt_in_if / skt_out_if: request and response channels
// Valid/ready channels carrying one operation item or one result item.
// ----------------------------------------------------------------------------
interface skt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] key;
  logic [31:0] value;
  logic [5:0]  index;

  modport source (output valid, op, key, value, index, input ready);
  modport sink   (input valid, op, key, value, index, output ready);
endinterface

interface skt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [6:0]  position;
  logic [31:0] entry_key;
  logic [31:0] entry_value;
  logic [6:0]  count;
  logic        last;

  modport source (output valid, status, found, position, entry_key, entry_value,
                  count, last, input ready);
  modport sink   (input valid, status, found, position, entry_key, entry_value,
                  count, last, output ready);
endinterface

// ----- rtl/skt_dp.sv -----
// ----------------------------------------------------------------------------
// skt_dp: sorted key table datapath
// Entry memory, search bounds, run pointers, count and result register.
// ----------------------------------------------------------------------------
module skt_dp (
  input  logic              clk,
  input  logic              rst,
  input  skt_pkg::dp_cmd_t  cmd,
  output skt_pkg::dp_stat_t stat,
  skt_in_if.sink            req,
  skt_out_if.source         rsp
);
  import skt_pkg::*;

  localparam int EW = KEY_WIDTH + VALUE_WIDTH;

  // entry memory, key in the upper half
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  // item and working registers
  logic [2:0]             op;
  logic [KEY_WIDTH-1:0]   key;
  logic [VALUE_WIDTH-1:0] val;
  logic [AW-1:0]          idx;
  logic [CW-1:0]          cnt;
  logic [CW-1:0]          lo;
  logic signed [CW:0]     hi;
  logic [AW-1:0]          mid;
  logic                   hit;
  logic [CW-1:0]          rb;
  logic [CW-1:0]          re;
  logic signed [CW:0]     ptr;
  logic [KEY_WIDTH-1:0]   sk;
  logic [VALUE_WIDTH-1:0] sv;

  logic [CW:0]            mid_sum;
  logic [AW-1:0]          mid_c;
  logic [CW-1:0]          run_len;
  logic [KEY_WIDTH-1:0]   rkey;
  logic [VALUE_WIDTH-1:0] rval;

  // result register
  logic                   o_valid;
  status_t                o_status;
  logic                   o_found;
  logic [CW-1:0]          o_pos;
  logic [KEY_WIDTH-1:0]   o_key;
  logic [VALUE_WIDTH-1:0] o_val;
  logic [CW-1:0]          o_cnt;
  logic                   o_last;

  assign rkey    = rdata[EW-1:VALUE_WIDTH];
  assign rval    = rdata[VALUE_WIDTH-1:0];
  assign mid_sum = {1'b0, lo} + hi[CW:0];
  assign mid_c   = mid_sum[AW:1];
  assign run_len = re - rb + CW'(1);

  // status back to the controller
  always_comb begin
    stat.op         = op;
    stat.lo_le_hi   = $signed({1'b0, lo}) <= hi;
    stat.eq         = rkey == key;
    stat.hit        = hit;
    stat.rb_gt0     = rb != '0;
    stat.up_ok      = (re + CW'(1)) < cnt;
    stat.ptr_ge_rb  = ptr >= $signed({1'b0, rb});
    stat.ptr_lt_cnt = ptr < $signed({1'b0, cnt});
    stat.idx_ok     = {1'b0, idx} < cnt;
    stat.full       = cnt == CW'(DEPTH);
    stat.fa_last    = (op == OP_READ_AT) || (ptr[CW-1:0] == re);
    stat.out_busy   = o_valid;
  end

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rdata;
    unique case (cmd.op)
      DC_RD_MID: begin rd_en = 1'b1; rd_addr = mid_c; end
      DC_RD_IDX: begin rd_en = 1'b1; rd_addr = idx; end
      DC_RD_DN:  begin rd_en = 1'b1; rd_addr = AW'(rb - CW'(1)); end
      DC_RD_UP:  begin rd_en = 1'b1; rd_addr = AW'(re + CW'(1)); end
      DC_RD_PTR: begin rd_en = 1'b1; rd_addr = ptr[AW-1:0]; end
      DC_MOV_UP: begin wr_en = 1'b1; wr_addr = AW'(ptr + (CW+1)'(1)); end
      DC_MOV_DN: begin wr_en = 1'b1; wr_addr = AW'(ptr[CW-1:0] - run_len); end
      DC_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = rb[AW-1:0];
        wr_data = {key, val};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      o_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) o_valid <= 1'b0;
      unique case (cmd.op)
        DC_LOAD: begin
          op  <= req.op;
          key <= req.key;
          val <= req.value;
          idx <= req.index;
          lo  <= '0;
          hi  <= $signed({1'b0, cnt}) - (CW+1)'(1);
          hit <= 1'b0;
        end
        DC_RD_MID: mid <= mid_c;
        DC_SRCH: begin
          if (rkey == key) begin
            hit <= 1'b1;
            sk  <= rkey;
            sv  <= rval;
          end else if (rkey < key) begin
            lo <= {1'b0, mid} + CW'(1);
          end else begin
            hi <= $signed({2'b0, mid}) - (CW+1)'(1);
          end
        end
        DC_RD_IDX:  ptr <= $signed({2'b0, idx});
        DC_SET_RUN: begin rb <= {1'b0, mid}; re <= {1'b0, mid}; end
        DC_STEP_DN: begin rb <= rb - CW'(1); sk <= rkey; sv <= rval; end
        DC_STEP_UP: re <= re + CW'(1);
        DC_SET_AT:  rb <= hit ? re + CW'(1) : lo;
        DC_INS_INIT: ptr <= $signed({1'b0, cnt}) - (CW+1)'(1);
        DC_MOV_UP:  ptr <= ptr - (CW+1)'(1);
        DC_INS_WR:  cnt <= cnt + CW'(1);
        DC_RM_INIT: ptr <= $signed({1'b0, re}) + (CW+1)'(1);
        DC_MOV_DN:  ptr <= ptr + (CW+1)'(1);
        DC_RM_DONE: cnt <= cnt - run_len;
        DC_PTR_RB:  ptr <= $signed({1'b0, rb});
        DC_EMIT: begin
          o_valid <= 1'b1;
          o_cnt   <= cnt;
          // only entry reads can end before the last item of a run
          o_last  <= (cmd.sel == EM_RDAT) ? stat.fa_last : 1'b1;
          unique case (cmd.sel)
            EM_MISS: begin
              o_status <= ST_MISS; o_found <= 1'b0; o_pos <= lo;
              o_key <= '0; o_val <= '0;
            end
            EM_INS: begin
              o_status <= cmd.st; o_found <= hit; o_pos <= rb;
              o_key <= key; o_val <= val;
            end
            EM_SAVED: begin
              o_status <= ST_OK; o_found <= 1'b1; o_pos <= rb;
              o_key <= sk; o_val <= sv;
            end
            EM_RDAT: begin
              o_status <= ST_OK; o_found <= op != OP_READ_AT;
              o_pos <= ptr[CW-1:0]; o_key <= rkey; o_val <= rval;
              ptr <= ptr + (CW+1)'(1);
            end
            default: begin
              o_status <= ST_RANGE; o_found <= 1'b0; o_pos <= {1'b0, idx};
              o_key <= '0; o_val <= '0;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.status      = o_status;
  assign rsp.found       = o_found;
  assign rsp.position    = o_pos;
  assign rsp.entry_key   = o_key;
  assign rsp.entry_value = o_val;
  assign rsp.count       = o_cnt;
  assign rsp.last        = o_last;

endmodule

// ----- rtl/skt_ctrl.sv -----
// ----------------------------------------------------------------------------
// skt_ctrl: sorted key table controller
// Sequences search, run scans, entry shifts and result emission.
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  skt_pkg::dp_stat_t stat,
  output skt_pkg::dp_cmd_t  cmd
);
  import skt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_AT, S_SRCH, S_CMP, S_DISP, S_DN_RD, S_DN_CMP,
    S_UP_RD, S_UP_CMP, S_AFTER, S_INS_AT, S_INS_CHK, S_INS_RD, S_INS_MV,
    S_INS_WR, S_RM_INIT, S_RM_RD, S_RM_MV, S_FA_RD, S_FA_EM, S_EMIT
  } state_t;

  state_t  state, state_next;
  emit_t   em_sel, em_sel_next;
  status_t em_st, em_st_next;

  assign in_ready = state == S_IDLE;

  // next state and command
  always_comb begin
    state_next  = state;
    em_sel_next = em_sel;
    em_st_next  = em_st;
    cmd.op      = DC_NOP;
    cmd.sel     = em_sel;
    cmd.st      = em_st;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.op = DC_LOAD; state_next = S_START;
      end
      S_START: priority if (stat.op == OP_READ_AT) state_next = S_AT;
        else if (stat.op > OP_READ_AT) state_next = S_IDLE;
        else state_next = S_SRCH;
      S_AT: if (stat.idx_ok) begin
        cmd.op = DC_RD_IDX; state_next = S_FA_EM;
      end else begin
        em_sel_next = EM_RANGE; em_st_next = ST_RANGE; state_next = S_EMIT;
      end
      S_SRCH: if (stat.lo_le_hi) begin
        cmd.op = DC_RD_MID; state_next = S_CMP;
      end else state_next = S_DISP;
      S_CMP: begin
        cmd.op = DC_SRCH;
        state_next = stat.eq ? S_DISP : S_SRCH;
      end
      S_DISP: begin
        cmd.op = DC_SET_RUN;
        priority if (stat.op == OP_INSERT) begin
          state_next = stat.hit ? S_UP_RD : S_INS_AT;
        end else if (!stat.hit) begin
          em_sel_next = EM_MISS; em_st_next = ST_MISS; state_next = S_EMIT;
        end else if (stat.op == OP_FIND) begin
          em_sel_next = EM_SAVED; em_st_next = ST_OK; state_next = S_EMIT;
        end else if (stat.op == OP_DEL_ONE) begin
          state_next = S_RM_INIT;
        end else state_next = S_DN_RD;
      end
      S_DN_RD: if (stat.rb_gt0) begin
        cmd.op = DC_RD_DN; state_next = S_DN_CMP;
      end else state_next = S_UP_RD;
      S_DN_CMP: if (stat.eq) begin
        cmd.op = DC_STEP_DN; state_next = S_DN_RD;
      end else state_next = S_UP_RD;
      S_UP_RD: if (stat.up_ok) begin
        cmd.op = DC_RD_UP; state_next = S_UP_CMP;
      end else state_next = S_AFTER;
      S_UP_CMP: if (stat.eq) begin
        cmd.op = DC_STEP_UP; state_next = S_UP_RD;
      end else state_next = S_AFTER;
      S_AFTER: priority if (stat.op == OP_INSERT) state_next = S_INS_AT;
        else if (stat.op == OP_FIND_ALL) begin
          cmd.op = DC_PTR_RB; state_next = S_FA_RD;
        end else state_next = S_RM_INIT;
      S_INS_AT: begin cmd.op = DC_SET_AT; state_next = S_INS_CHK; end
      S_INS_CHK: if (stat.full) begin
        em_sel_next = EM_INS; em_st_next = ST_FULL; state_next = S_EMIT;
      end else begin
        cmd.op = DC_INS_INIT; state_next = S_INS_RD;
      end
      S_INS_RD: if (stat.ptr_ge_rb) begin
        cmd.op = DC_RD_PTR; state_next = S_INS_MV;
      end else state_next = S_INS_WR;
      S_INS_MV: begin cmd.op = DC_MOV_UP; state_next = S_INS_RD; end
      S_INS_WR: begin
        cmd.op = DC_INS_WR;
        em_sel_next = EM_INS; em_st_next = ST_OK; state_next = S_EMIT;
      end
      S_RM_INIT: begin cmd.op = DC_RM_INIT; state_next = S_RM_RD; end
      S_RM_RD: if (stat.ptr_lt_cnt) begin
        cmd.op = DC_RD_PTR; state_next = S_RM_MV;
      end else begin
        cmd.op = DC_RM_DONE;
        em_sel_next = EM_SAVED; em_st_next = ST_OK; state_next = S_EMIT;
      end
      S_RM_MV: begin cmd.op = DC_MOV_DN; state_next = S_RM_RD; end
      S_FA_RD: begin cmd.op = DC_RD_PTR; state_next = S_FA_EM; end
      S_FA_EM: if (!stat.out_busy) begin
        cmd.op = DC_EMIT; cmd.sel = EM_RDAT; cmd.st = ST_OK;
        state_next = stat.fa_last ? S_IDLE : S_FA_RD;
      end
      S_EMIT: if (!stat.out_busy) begin
        cmd.op = DC_EMIT; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and registered emit selection
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      em_sel <= EM_MISS;
      em_st  <= ST_OK;
    end else begin
      state  <= state_next;
      em_sel <= em_sel_next;
      em_st  <= em_st_next;
    end
  end

endmodule

// ----- rtl/sorted_key_table.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table: key/value table kept in ascending key order
// Binary search, sorted insert, find, find-all, delete and read-at-index.
// ----------------------------------------------------------------------------
// Use: operations arrive on the req channel (op, key, value, index) and
// results leave on the rsp channel, both valid/ready; an item moves when
// valid and ready are high at a clock edge. One operation is worked at a
// time; req is ready only when the previous one has issued all its results.
// Every operation gives one result, except find-all (one per equal entry,
// last set on the final one) and unused opcodes (no result).
// Each search probe is a memory read followed by a compare. Scanning a run
// of equal keys and shifting entries on insert or delete go one entry at a
// time, each a read then a compare or a move, set by the single read port
// of the entry memory.
// The result sits in an output register; while rsp is stalled the next
// operation is still accepted and worked until it has a result to emit.
// Reset (rst, synchronous) empties the table at once; entry contents are
// left as they were and are never read beyond the count.
// ----------------------------------------------------------------------------
module sorted_key_table (
  input  logic      clk,
  input  logic      rst,
  skt_in_if.sink    req,
  skt_out_if.source rsp
);
  import skt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  skt_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );

`ifndef SYNTHESIS
  // a miss never reports a hit
  a_miss_not_found: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_MISS) |-> !rsp.found)
    else $error("miss result reports found");

  // a full rejection only with a full table
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |-> (rsp.count == CW'(DEPTH)))
    else $error("table full reported below depth");

  // one item at a time: ready drops after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second item accepted while busy");

  // count never exceeds depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.count <= CW'(DEPTH)))
    else $error("count beyond depth");
`endif

endmodule
